// ----- sv/prrp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrp_pkg
// Shared types and constants for the priority round-robin picker.
// ----------------------------------------------------------------------------
package prrp_pkg;

    localparam int LEVELS    = 8;
    localparam int MAX_TASKS = 32;
    localparam int ID_W      = 5;
    localparam int LVL_W     = 3;
    localparam int CNT_W     = 6;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_STATUS = 2'd2,
        OP_CHOOSE = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]       operation;
        logic [ID_W-1:0]  context_id;
        logic [LVL_W-1:0] priority_req;
        logic             finished;
        logic             waiting;
    } t_in_beat;

    typedef struct packed {
        logic             result_status;
        logic             chosen_valid;
        logic [ID_W-1:0]  chosen_id;
        logic             current_valid;
        logic [ID_W-1:0]  current_id;
        logic             any_ready;
        logic [CNT_W-1:0] task_count;
    } t_out_beat;

    // controller to datapath
    typedef struct packed {
        logic capture;    // latch input beat
        logic do_simple;  // execute add/remove/status
        logic scan_start; // begin choose scan
        logic scan_step;  // advance scan one task or one level
        logic do_move;    // move chosen task to tail
        logic finish;     // latch result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_choose;
        logic scan_done;
        logic scan_found;
    } t_sts;

endpackage

// ----- sv/prrp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrp_in_if / prrp_out_if
// Valid/ready channels carrying the input and result beats.
// ----------------------------------------------------------------------------
interface prrp_in_if;
    import prrp_pkg::*;
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface prrp_out_if;
    import prrp_pkg::*;
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/prrp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrp_ctrl
// Sequencer: accept a beat, run the operation, present the result.
// ----------------------------------------------------------------------------
module prrp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  prrp_pkg::t_sts   i_sts,
    output prrp_pkg::t_cmd   o_cmd
);
    import prrp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_SCAN, S_MOVE, S_FINISH, S_OUT
    } t_state;

    t_state r_state, n_state;

    // accept only when idle; result register drains in S_OUT
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_choose) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.do_simple = 1'b1;
                    n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = i_sts.scan_found ? S_MOVE : S_FINISH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_MOVE: begin
                o_cmd.do_move = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

// ----- sv/prrp_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrp_dp
// Task lists, flags and the scan walker for the picker.
// ----------------------------------------------------------------------------
module prrp_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  prrp_pkg::t_in_beat  i_in,
    input  prrp_pkg::t_cmd      i_cmd,
    output prrp_pkg::t_sts      o_sts,
    output prrp_pkg::t_out_beat o_out
);
    import prrp_pkg::*;

    localparam int LSEL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    logic [MAX_TASKS-1:0] r_present, r_fin, r_wait;
    logic [LSEL_W-1:0]    r_level [MAX_TASKS];
    logic [ID_W-1:0]      r_next  [MAX_TASKS];
    logic [ID_W-1:0]      r_prev  [MAX_TASKS];
    logic [ID_W-1:0]      r_head  [LEVELS];
    logic [ID_W-1:0]      r_tail  [LEVELS];
    logic [LEVELS-1:0]    r_nonempty;
    logic                 r_cur_valid;
    logic [ID_W-1:0]      r_cur_id;
    logic [CNT_W-1:0]     r_count;

    t_in_beat             r_beat;
    logic [LSEL_W-1:0]    r_scan_lvl;
    logic [ID_W-1:0]      r_scan_id;
    logic                 r_scan_on_list;
    logic                 r_done, r_found;
    logic                 r_status;
    t_out_beat            r_out;

    logic                 known;
    logic                 id_ok;
    logic [LSEL_W-1:0]    add_lvl;
    logic [MAX_TASKS-1:0] ready_vec;
    logic                 cur_ready;
    logic                 cur_is_tail;
    logic                 lvl_last;
    logic [LSEL_W-1:0]    lvl_inc;

    assign id_ok     = ({1'b0, r_beat.context_id} < (ID_W+1)'(MAX_TASKS));
    assign known     = id_ok && r_present[r_beat.context_id];
    assign add_lvl   = (32'(r_beat.priority_req) >= 32'(LEVELS))
                       ? LSEL_W'(LEVELS - 1) : LSEL_W'(r_beat.priority_req);
    assign ready_vec = r_present & ~r_fin & ~r_wait;
    assign cur_ready = ready_vec[r_scan_id];
    assign cur_is_tail = (r_tail[r_scan_lvl] == r_scan_id);
    assign lvl_last  = (32'(r_scan_lvl) == LEVELS - 1);
    assign lvl_inc   = r_scan_lvl + LSEL_W'(1);

    assign o_sts.is_choose  = (r_beat.operation == OP_CHOOSE);
    assign o_sts.scan_done  = r_done;
    assign o_sts.scan_found = r_found;
    assign o_out            = r_out;

    // unlink a task; with reappend, put it back at the tail of its level
    task automatic unlink(input logic [ID_W-1:0] id, input logic reappend);
        logic [LSEL_W-1:0] lv;
        logic              is_h, is_t;
        lv   = r_level[id];
        is_h = (r_head[lv] == id);
        is_t = (r_tail[lv] == id);
        if (is_h && is_t) begin
            // sole entry: position unchanged either way
        end else if (reappend) begin
            if (is_t) begin
                // already at the tail
            end else begin
                if (is_h) r_head[lv] <= r_next[id];
                else      r_next[r_prev[id]] <= r_next[id];
                r_prev[r_next[id]] <= r_prev[id];
                r_next[r_tail[lv]] <= id;
                r_prev[id]         <= r_tail[lv];
                r_tail[lv]         <= id;
                r_next[id]         <= id;
            end
        end else begin
            if (is_h) r_head[lv] <= r_next[id];
            else      r_next[r_prev[id]] <= r_next[id];
            if (is_t) r_tail[lv] <= r_prev[id];
            else      r_prev[r_next[id]] <= r_prev[id];
        end
    endtask

    // input capture, scan walker and result register (no reset needed)
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_beat <= i_in;
        if (i_cmd.scan_start) begin
            r_scan_lvl     <= '0;
            r_scan_on_list <= 1'b0;
            r_done         <= 1'b0;
            r_found        <= 1'b0;
        end else if (i_cmd.scan_step) begin
            // one task or one level per cycle
            if (!r_scan_on_list) begin
                if (r_nonempty[r_scan_lvl]) begin
                    r_scan_id      <= r_head[r_scan_lvl];
                    r_scan_on_list <= 1'b1;
                end else if (lvl_last) begin
                    r_done <= 1'b1;
                end else begin
                    r_scan_lvl <= lvl_inc;
                end
            end else if (cur_ready) begin
                r_done  <= 1'b1;
                r_found <= 1'b1;
            end else if (cur_is_tail) begin
                r_scan_on_list <= 1'b0;
                if (lvl_last) r_done <= 1'b1;
                else          r_scan_lvl <= lvl_inc;
            end else begin
                r_scan_id <= r_next[r_scan_id];
            end
        end
        if (i_cmd.finish) begin
            r_out.result_status <= (r_beat.operation == OP_CHOOSE) ? 1'b0 : r_status;
            r_out.chosen_valid  <= (r_beat.operation == OP_CHOOSE) && r_found;
            r_out.chosen_id     <= ((r_beat.operation == OP_CHOOSE) && r_found)
                                   ? r_scan_id : '0;
            r_out.current_valid <= r_cur_valid;
            r_out.current_id    <= r_cur_valid ? r_cur_id : '0;
            r_out.any_ready     <= |ready_vec;
            r_out.task_count    <= r_count;
        end
    end

    // list links and levels: unwritten entries are never followed
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_simple && r_beat.operation == OP_ADD && id_ok && !known) begin
            if (r_nonempty[add_lvl]) begin
                r_next[r_tail[add_lvl]] <= r_beat.context_id;
                r_prev[r_beat.context_id] <= r_tail[add_lvl];
            end else begin
                r_head[add_lvl] <= r_beat.context_id;
            end
            r_tail[add_lvl] <= r_beat.context_id;
            r_next[r_beat.context_id] <= r_beat.context_id;
            r_level[r_beat.context_id] <= add_lvl;
        end
        if (i_cmd.do_simple && r_beat.operation == OP_REMOVE && known) begin
            unlink(r_beat.context_id, 1'b0);
        end
        if (i_cmd.do_move) begin
            unlink(r_scan_id, 1'b1);
        end
    end

    // control flags, count and current task
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_fin       <= '0;
            r_wait      <= '0;
            r_nonempty  <= '0;
            r_cur_valid <= 1'b0;
            r_cur_id    <= '0;
            r_count     <= '0;
            r_status    <= 1'b0;
        end else begin
            if (i_cmd.do_simple) begin
                case (r_beat.operation)
                    OP_ADD: begin
                        r_status <= !id_ok || known;
                        if (id_ok && !known) begin
                            r_present[r_beat.context_id] <= 1'b1;
                            r_fin[r_beat.context_id]     <= 1'b0;
                            r_wait[r_beat.context_id]    <= 1'b0;
                            r_nonempty[add_lvl]          <= 1'b1;
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    OP_REMOVE: begin
                        r_status <= !known;
                        if (known) begin
                            r_present[r_beat.context_id] <= 1'b0;
                            r_count <= r_count - CNT_W'(1);
                            if (r_head[r_level[r_beat.context_id]] == r_beat.context_id &&
                                r_tail[r_level[r_beat.context_id]] == r_beat.context_id)
                                r_nonempty[r_level[r_beat.context_id]] <= 1'b0;
                        end
                    end
                    OP_STATUS: begin
                        r_status <= !known;
                        if (known) begin
                            r_fin[r_beat.context_id]  <= r_beat.finished;
                            r_wait[r_beat.context_id] <= r_beat.waiting;
                        end
                    end
                    default: r_status <= 1'b0;
                endcase
            end
            if (i_cmd.do_move) begin
                r_cur_valid <= 1'b1;
                r_cur_id    <= r_scan_id;
            end else if (i_cmd.scan_start) begin
                r_cur_valid <= 1'b0;
                r_cur_id    <= '0;
            end
        end
    end

endmodule

// ----- sv/priority_round_robin_picker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_round_robin_picker
// Add, remove and set-status pass through S_DECODE and S_FINISH before the result
// is presented in S_OUT. Choose also runs S_SCAN, where the walker visits one task
// or one level per cycle, and S_MOVE, where a found task is moved to the tail.
// One beat is in flight at a time; the next is accepted the cycle after the
// result beat. Synchronous active-low reset empties all lists and current task.
// ----------------------------------------------------------------------------
module priority_round_robin_picker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prrp_in_if.sink    i_in,
    prrp_out_if.source o_out
);
    import prrp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    prrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    prrp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in.data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out.data)
    );

    // no new beat accepted while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready) else $error("accept during result");

    // a chosen task is always reported as current
    a_chosen_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.chosen_valid) |->
        (o_out.data.current_valid && o_out.data.current_id == o_out.data.chosen_id))
        else $error("chosen not current");

    // task count never exceeds capacity
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.task_count <= CNT_W'(MAX_TASKS)))
        else $error("task count overflow");

endmodule
